// ===== hdl/vertex_rotate_project_defines.svh =====
// Assertion macros shared by the RTL. Define ASSERT_OFF to remove them.
`ifndef VERTEX_ROTATE_PROJECT_DEFINES_SVH
`define VERTEX_ROTATE_PROJECT_DEFINES_SVH

`ifndef ASSERT_OFF
// Property that must hold in the same cycle.
`define VRP_ASSERT_NOW(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");
// Property whose consequent must hold in the cycle after the antecedent.
`define VRP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define VRP_ASSERT_NOW(label, clk, rst, cond)
`define VRP_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== hdl/vrp_pkg.sv =====
package vrp_pkg;

   localparam int SCREEN_WIDTH  = 640;
   localparam int SCREEN_HEIGHT = 480;

   // Rotated depth is offset by 5.0 in Q8.8.
   localparam int DEPTH_OFFSET = 1280;

   // Width of the dividend magnitude (quotient bits, one divider stage each).
   localparam int DIV_W = 35;
   // Width of the divisor (positive depth).
   localparam int DVS_W = 21;

   typedef enum logic [2:0] {
      REG_COS_YAW    = 3'd0,
      REG_SIN_YAW    = 3'd1,
      REG_COS_PITCH  = 3'd2,
      REG_SIN_PITCH  = 3'd3,
      REG_COS_ROLL   = 3'd4,
      REG_SIN_ROLL   = 3'd5,
      REG_VIEW_SCALE = 3'd6
   } reg_index_type;

   typedef struct packed {
      logic signed [15:0] vertex_x;
      logic signed [15:0] vertex_y;
      logic signed [15:0] vertex_z;
   } vertex_type;

   typedef struct packed {
      logic signed [15:0] screen_x;
      logic signed [15:0] screen_y;
      logic               behind_camera;
   } screen_type;

   // Sideband that travels with each item through the divider.
   typedef struct packed {
      logic valid;
      logic behind;
      logic neg_x;
      logic neg_y;
   } div_ctl_type;

   // Divide by 2^14, rounding to nearest with ties away from zero.
   function automatic logic signed [37:0] rnd14(input logic signed [37:0] v);
      logic signed [37:0] t;
      t = v + (v[37] ? 38'sd8191 : 38'sd8192);
      return t >>> 14;
   endfunction

endpackage

// ===== hdl/vertex_rotate_project.sv =====
// An accepted request transaction passes the arithmetic stages, the divider
// stages and the output register before rsp_valid. Throughput: one vertex per
// cycle unless stalled; the 35-stage restoring divider (one quotient bit per
// stage) sets the depth, every stage takes a new item. When rsp_valid is high
// and rsp_ready low, the whole pipeline holds. Reset (synchronous, active high)
// empties the pipeline and loads the identity rotation with a view scale of 300.
`include "vertex_rotate_project_defines.svh"

module vertex_rotate_project import vrp_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  vertex_type   req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output screen_type   rsp_data,
   input  logic         csr_we,
   input  logic [2:0]   csr_addr,
   input  logic [15:0]  csr_wdata
);

   localparam logic signed [36:0] CX_OFS = 37'(SCREEN_WIDTH / 2 * 16);
   localparam logic signed [36:0] CY_OFS = 37'(SCREEN_HEIGHT / 2 * 16);
   localparam logic signed [21:0] DEPTH_OFS = 22'(DEPTH_OFFSET);

   // ------------------------------------------------------------------
   // Configuration registers. Software must write them only while idle; not enforced.
   // ------------------------------------------------------------------
   logic signed [15:0] cy_ff, sy_ff, cp_ff, sp_ff, cr_ff, sr_ff;
   logic        [9:0]  vs_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cy_ff <= 16'sd16384;
         sy_ff <= '0;
         cp_ff <= 16'sd16384;
         sp_ff <= '0;
         cr_ff <= 16'sd16384;
         sr_ff <= '0;
         vs_ff <= 10'd300;
      end else if (csr_we) begin
         case (reg_index_type'(csr_addr))
            REG_COS_YAW:    cy_ff <= csr_wdata;
            REG_SIN_YAW:    sy_ff <= csr_wdata;
            REG_COS_PITCH:  cp_ff <= csr_wdata;
            REG_SIN_PITCH:  sp_ff <= csr_wdata;
            REG_COS_ROLL:   cr_ff <= csr_wdata;
            REG_SIN_ROLL:   sr_ff <= csr_wdata;
            REG_VIEW_SCALE: vs_ff <= csr_wdata[9:0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Pipeline control. All stages advance together unless a finished
   // result waits in the output register and the consumer is not ready.
   // ------------------------------------------------------------------
   logic       en;
   logic [7:0] v_ff;
   logic       rsp_valid_ff;

   assign en        = !rsp_valid_ff || rsp_ready;
   assign req_ready = en;

   div_ctl_type div_ctl_in, div_ctl_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[6:0], req_valid};
      end
   end

   // Stage 1: yaw products.
   logic signed [31:0] s1_xcy_ff, s1_zsy_ff, s1_zcy_ff, s1_xsy_ff;
   logic signed [15:0] s1_y_ff;
   // Stage 2: yaw sums, rounded.
   logic signed [18:0] s2_x_ff, s2_z_ff;
   logic signed [15:0] s2_y_ff;
   // Stage 3: pitch products.
   logic signed [34:0] s3_ycp_ff, s3_zsp_ff, s3_zcp_ff, s3_ysp_ff;
   logic signed [18:0] s3_x_ff;
   // Stage 4: pitch sums, rounded.
   logic signed [20:0] s4_y_ff, s4_z_ff;
   logic signed [18:0] s4_x_ff;
   // Stage 5: roll products and the offset depth.
   logic signed [36:0] s5_xcr_ff, s5_ysr_ff, s5_ycr_ff, s5_xsr_ff;
   logic signed [21:0] s5_depth_ff;
   // Stage 6: roll sums, rounded.
   logic signed [21:0] s6_x_ff, s6_y_ff, s6_depth_ff;
   // Stage 7: field of view scaling.
   logic signed [32:0] s7_nx_ff, s7_ny_ff;
   logic signed [21:0] s7_depth_ff;
   // Stage 8: sign and magnitude for the divider.
   logic [DIV_W-1:0]   s8_mx_ff, s8_my_ff;
   logic [DVS_W-1:0]   s8_dvs_ff;
   logic               s8_nx_ff, s8_ny_ff, s8_behind_ff;

   logic signed [37:0] s2_x_in, s2_z_in, s4_y_in, s4_z_in, s6_x_in, s6_y_in;
   logic        [32:0] s8_ax_in, s8_ay_in;
   logic               s8_behind_in;

   assign s2_x_in = rnd14(38'(s1_xcy_ff) + 38'(s1_zsy_ff));
   assign s2_z_in = rnd14(38'(s1_zcy_ff) - 38'(s1_xsy_ff));
   assign s4_y_in = rnd14(38'(s3_ycp_ff) - 38'(s3_zsp_ff));
   assign s4_z_in = rnd14(38'(s3_zcp_ff) + 38'(s3_ysp_ff));
   assign s6_x_in = rnd14(38'(s5_xcr_ff) - 38'(s5_ysr_ff));
   assign s6_y_in = rnd14(38'(s5_ycr_ff) + 38'(s5_xsr_ff));

   assign s8_ax_in     = s7_nx_ff[32] ? 33'(-s7_nx_ff) : 33'(s7_nx_ff);
   assign s8_ay_in     = s7_ny_ff[32] ? 33'(-s7_ny_ff) : 33'(s7_ny_ff);
   // A depth of zero or less means the vertex is at or behind the camera.
   assign s8_behind_in = s7_depth_ff[21] || (s7_depth_ff == '0);

   always_ff @(posedge clock) begin
      if (en) begin
         s1_xcy_ff <= req_data.vertex_x * cy_ff;
         s1_zsy_ff <= req_data.vertex_z * sy_ff;
         s1_zcy_ff <= req_data.vertex_z * cy_ff;
         s1_xsy_ff <= req_data.vertex_x * sy_ff;
         s1_y_ff   <= req_data.vertex_y;

         s2_x_ff <= s2_x_in[18:0];
         s2_z_ff <= s2_z_in[18:0];
         s2_y_ff <= s1_y_ff;

         s3_ycp_ff <= 35'(s2_y_ff * cp_ff);
         s3_zsp_ff <= 35'(s2_z_ff * sp_ff);
         s3_zcp_ff <= 35'(s2_z_ff * cp_ff);
         s3_ysp_ff <= 35'(s2_y_ff * sp_ff);
         s3_x_ff   <= s2_x_ff;

         s4_y_ff <= s4_y_in[20:0];
         s4_z_ff <= s4_z_in[20:0];
         s4_x_ff <= s3_x_ff;

         s5_xcr_ff   <= 37'(s4_x_ff * cr_ff);
         s5_ysr_ff   <= 37'(s4_y_ff * sr_ff);
         s5_ycr_ff   <= 37'(s4_y_ff * cr_ff);
         s5_xsr_ff   <= 37'(s4_x_ff * sr_ff);
         s5_depth_ff <= 22'(s4_z_ff) + DEPTH_OFS;

         s6_x_ff     <= s6_x_in[21:0];
         s6_y_ff     <= s6_y_in[21:0];
         s6_depth_ff <= s5_depth_ff;

         s7_nx_ff    <= 33'(s6_x_ff * $signed({1'b0, vs_ff}));
         s7_ny_ff    <= 33'(s6_y_ff * $signed({1'b0, vs_ff}));
         s7_depth_ff <= s6_depth_ff;

         // The factor of 16 turns the quotient into Q12.4.
         s8_mx_ff     <= {s8_ax_in[30:0], 4'b0000};
         s8_my_ff     <= {s8_ay_in[30:0], 4'b0000};
         s8_nx_ff     <= s7_nx_ff[32];
         s8_ny_ff     <= s7_ny_ff[32];
         s8_behind_ff <= s8_behind_in;
         // Keep the divisor nonzero for items that skip the division.
         s8_dvs_ff    <= s8_behind_in ? DVS_W'(1) : s7_depth_ff[DVS_W-1:0];
      end
   end

   // ------------------------------------------------------------------
   // Perspective division, both coordinates by the same depth.
   // ------------------------------------------------------------------
   logic [DIV_W-1:0] qx, qy;

   assign div_ctl_in = '{valid: v_ff[7], behind: s8_behind_ff,
                         neg_x: s8_nx_ff, neg_y: s8_ny_ff};

   vrp_div u_div (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .ctl_in  (div_ctl_in),
      .mag_x   (s8_mx_ff),
      .mag_y   (s8_my_ff),
      .divisor (s8_dvs_ff),
      .ctl_out (div_ctl_out),
      .quot_x  (qx),
      .quot_y  (qy)
   );

   // ------------------------------------------------------------------
   // Sign restore, screen centre offset, saturation, output register.
   // ------------------------------------------------------------------
   logic signed [36:0] sx_sum, sy_sum;
   logic signed [15:0] sx_sat, sy_sat;
   screen_type         rsp_in, rsp_ff;

   assign sx_sum = (div_ctl_out.neg_x ? -37'(qx) : 37'(qx)) + CX_OFS;
   assign sy_sum = (div_ctl_out.neg_y ? -37'(qy) : 37'(qy)) + CY_OFS;

   always_comb begin
      if (sx_sum > 37'sd32767) begin
         sx_sat = 16'sh7fff;
      end else if (sx_sum < -37'sd32768) begin
         sx_sat = 16'sh8000;
      end else begin
         sx_sat = sx_sum[15:0];
      end
      if (sy_sum > 37'sd32767) begin
         sy_sat = 16'sh7fff;
      end else if (sy_sum < -37'sd32768) begin
         sy_sat = 16'sh8000;
      end else begin
         sy_sat = sy_sum[15:0];
      end
      // A vertex behind the camera reports the origin and the flag.
      if (div_ctl_out.behind) begin
         rsp_in = '{screen_x: '0, screen_y: '0, behind_camera: 1'b1};
      end else begin
         rsp_in = '{screen_x: sx_sat, screen_y: sy_sat, behind_camera: 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= div_ctl_out.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // ------------------------------------------------------------------
   // Assertions.
   // ------------------------------------------------------------------
   // A flagged result always carries the origin.
   `VRP_ASSERT_NOW(a_behind_zero, clock, reset, !(rsp_valid && rsp_data.behind_camera) || (rsp_data.screen_x == 16'sd0 && rsp_data.screen_y == 16'sd0))
   // The input side is only held off by a waiting result.
   `VRP_ASSERT_NOW(a_ready_stall, clock, reset, req_ready || rsp_valid)
   // A stall freezes the divider output stage.
   `VRP_ASSERT_NEXT(a_div_hold, clock, reset, !en, $stable(div_ctl_out))
   // A valid item leaving the divider lands in the output register.
   `VRP_ASSERT_NEXT(a_div_to_rsp, clock, reset, en && div_ctl_out.valid, rsp_valid)

endmodule

// ===== hdl/vrp_div.sv =====
module vrp_div import vrp_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  div_ctl_type              ctl_in,
   input  logic        [DIV_W-1:0]  mag_x,
   input  logic        [DIV_W-1:0]  mag_y,
   input  logic        [DVS_W-1:0]  divisor,
   output div_ctl_type              ctl_out,
   output logic        [DIV_W-1:0]  quot_x,
   output logic        [DIV_W-1:0]  quot_y
);

   // Each stage shifts one dividend bit into the remainder and one quotient
   // bit into the low end of the same shift register.
   div_ctl_type              ctl_ff [DIV_W];
   logic        [DVS_W-1:0]  rem_x_ff [DIV_W];
   logic        [DVS_W-1:0]  rem_y_ff [DIV_W];
   logic        [DIV_W-1:0]  dq_x_ff [DIV_W];
   logic        [DIV_W-1:0]  dq_y_ff [DIV_W];
   logic        [DVS_W-1:0]  dvs_ff [DIV_W];

   function automatic logic [DVS_W+DIV_W-1:0] div_step(
      input logic [DVS_W-1:0] rem,
      input logic [DIV_W-1:0] dq,
      input logic [DVS_W-1:0] d
   );
      logic [DVS_W:0]   trial;
      logic             ge;
      logic [DVS_W:0]   diff;
      trial = {rem, dq[DIV_W-1]};
      ge    = trial >= {1'b0, d};
      diff  = trial - {1'b0, d};
      return {(ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0]), dq[DIV_W-2:0], ge};
   endfunction

   genvar k;
   generate
      for (k = 0; k < DIV_W; k++) begin : g_stage
         div_ctl_type              ctl_in_s;
         logic        [DVS_W-1:0]  rem_in_x;
         logic        [DVS_W-1:0]  rem_in_y;
         logic        [DIV_W-1:0]  dq_in_x;
         logic        [DIV_W-1:0]  dq_in_y;
         logic        [DVS_W-1:0]  dvs_in;
         logic [DVS_W+DIV_W-1:0]   step_x;
         logic [DVS_W+DIV_W-1:0]   step_y;

         if (k == 0) begin : g_first
            assign ctl_in_s = ctl_in;
            assign rem_in_x = '0;
            assign rem_in_y = '0;
            assign dq_in_x  = mag_x;
            assign dq_in_y  = mag_y;
            assign dvs_in   = divisor;
         end else begin : g_next
            assign ctl_in_s = ctl_ff[k-1];
            assign rem_in_x = rem_x_ff[k-1];
            assign rem_in_y = rem_y_ff[k-1];
            assign dq_in_x  = dq_x_ff[k-1];
            assign dq_in_y  = dq_y_ff[k-1];
            assign dvs_in   = dvs_ff[k-1];
         end

         assign step_x = div_step(rem_in_x, dq_in_x, dvs_in);
         assign step_y = div_step(rem_in_y, dq_in_y, dvs_in);

         always_ff @(posedge clock) begin
            if (reset) begin
               ctl_ff[k] <= '0;
            end else if (en) begin
               ctl_ff[k] <= ctl_in_s;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_x_ff[k] <= step_x[DVS_W+DIV_W-1:DIV_W];
               rem_y_ff[k] <= step_y[DVS_W+DIV_W-1:DIV_W];
               dq_x_ff[k]  <= step_x[DIV_W-1:0];
               dq_y_ff[k]  <= step_y[DIV_W-1:0];
               dvs_ff[k]   <= dvs_in;
            end
         end
      end
   endgenerate

   assign ctl_out = ctl_ff[DIV_W-1];
   assign quot_x  = dq_x_ff[DIV_W-1];
   assign quot_y  = dq_y_ff[DIV_W-1];

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import vrp_pkg::*;

   // Index 7 is past the end of the register file; writes to it must be ignored.
   localparam logic [2:0] REG_UNUSED = 3'd7;
   localparam int CYCLE_LIMIT = 300000;
   // The block's pipeline depth sets how long an answer takes; leave some margin on top.
   localparam int SETTLE_CYCLES = 60;

   // The scoreboard keeps its own copy of the camera registers. It predicts the
   // screen position of each accepted vertex and queues it for the response
   // side to check in order.
   class screen_scoreboard;
      logic signed [15:0] cos_yaw, sin_yaw, cos_pitch, sin_pitch, cos_roll, sin_roll;
      logic [9:0]         view_scale;
      screen_type         expected_q[$];
      int                 failures, checked, behind_seen;

      function void load_defaults();
         cos_yaw = 16'sd16384;   sin_yaw = 16'sd0;
         cos_pitch = 16'sd16384; sin_pitch = 16'sd0;
         cos_roll = 16'sd16384;  sin_roll = 16'sd0;
         view_scale = 10'd300;
      endfunction

      function void write_reg(logic [2:0] idx, logic [15:0] val);
         case (idx)
            REG_COS_YAW:    cos_yaw = val;
            REG_SIN_YAW:    sin_yaw = val;
            REG_COS_PITCH:  cos_pitch = val;
            REG_SIN_PITCH:  sin_pitch = val;
            REG_COS_ROLL:   cos_roll = val;
            REG_SIN_ROLL:   sin_roll = val;
            REG_VIEW_SCALE: view_scale = val[9:0];
            default: ;
         endcase
      endfunction

      // Divide by 2^14, rounding to nearest with ties away from zero.
      function longint round_q14(longint v);
         if (v >= 0) return (v + 8192) >>> 14;
         return -((-v + 8192) >>> 14);
      endfunction

      function logic signed [15:0] clamp16(longint v);
         if (v > 32767) return 16'sd32767;
         if (v < -32768) return -16'sd32768;
         return v[15:0];
      endfunction

      function void note_vertex(vertex_type v);
         longint x, y, z, nx, ny, nz, depth, scale;
         screen_type s;
         x = v.vertex_x; y = v.vertex_y; z = v.vertex_z;
         scale = view_scale;
         nx = round_q14(x * cos_yaw + z * sin_yaw);
         nz = round_q14(z * cos_yaw - x * sin_yaw);
         x = nx; z = nz;
         // Both pitch terms use the y and z coming out of the yaw step.
         ny = round_q14(y * cos_pitch - z * sin_pitch);
         nz = round_q14(z * cos_pitch + y * sin_pitch);
         y = ny; z = nz;
         nx = round_q14(x * cos_roll - y * sin_roll);
         y = round_q14(y * cos_roll + x * sin_roll);
         x = nx;
         depth = z + DEPTH_OFFSET;
         if (depth <= 0) begin
            s = '{screen_x: 16'sd0, screen_y: 16'sd0, behind_camera: 1'b1};
         end else begin
            s.screen_x = clamp16((x * scale * 16) / depth + (SCREEN_WIDTH / 2) * 16);
            s.screen_y = clamp16((y * scale * 16) / depth + (SCREEN_HEIGHT / 2) * 16);
            s.behind_camera = 1'b0;
         end
         expected_q.push_back(s);
      endfunction

      function void check_screen(screen_type got);
         screen_type want;
         if (expected_q.size() == 0) begin
            $error("response transaction with no vertex outstanding");
            failures++;
            return;
         end
         want = expected_q.pop_front();
         checked++;
         if (want.behind_camera) behind_seen++;
         if (got.screen_x !== want.screen_x) begin
            $error("screen_x: expected %0d, got %0d", want.screen_x, got.screen_x);
            failures++;
         end
         if (got.screen_y !== want.screen_y) begin
            $error("screen_y: expected %0d, got %0d", want.screen_y, got.screen_y);
            failures++;
         end
         if (got.behind_camera !== want.behind_camera) begin
            $error("behind_camera: expected %0b, got %0b", want.behind_camera,
                   got.behind_camera);
            failures++;
         end
      endfunction

      function int pending();
         return expected_q.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   vertex_type req_data = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   screen_type rsp_data;
   logic       csr_we = 1'b0;
   logic [2:0] csr_addr = '0;
   logic [15:0] csr_wdata = '0;

   screen_scoreboard sb = new();

   // When calm is set neither side idles, giving a stretch of full-rate traffic.
   bit calm = 1'b0;
   // Raised once by the stimulus to ask the receiver for a long hold-off.
   bit hold_request = 1'b0;
   bit hold_done = 1'b0;
   int hold_count = 0;
   int cycle_count = 0;

   always #6 clock = ~clock;

   vertex_rotate_project dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_addr(csr_addr), .csr_wdata(csr_wdata)
   );

   // Watchdog: a correct run finishes far below this bound.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Response side. A transaction completes at an edge where rsp_valid and
   // rsp_ready were both high; the ready for the next cycle is then chosen.
   // The long hold-off is counted here so that the sender keeps pushing and the
   // pipeline backs up into req_ready.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            sb.check_screen(rsp_data);
         end
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_count = 300;
         end
         if (hold_count > 0) begin
            hold_count = hold_count - 1;
            rsp_ready <= 1'b0;
         end else if (calm) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= 31);
         end
      end
   end

   // Offer one vertex and wait for the block to take it. An optional idle gap
   // comes first, so gaps land on every phase of the pipeline.
   task automatic send_vertex(input vertex_type v);
      int gap;
      gap = 0;
      if (!calm) begin
         while ($urandom_range(0, 99) < 31) gap++;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= v;
      do @(posedge clock); while (!req_ready);
      sb.note_vertex(v);
   endtask

   task automatic send_xyz(input int x, input int y, input int z);
      vertex_type v;
      v.vertex_x = x[15:0];
      v.vertex_y = y[15:0];
      v.vertex_z = z[15:0];
      send_vertex(v);
   endtask

   // Stop offering and let every outstanding transaction drain, then give the
   // pipeline its full latency so the register file is truly quiet.
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [2:0] idx, input logic [15:0] val);
      csr_we <= 1'b1;
      csr_addr <= idx;
      csr_wdata <= val;
      sb.write_reg(idx, val);
      @(posedge clock);
   endtask

   task automatic load_camera(input int cy, input int sy, input int cp, input int sp,
                              input int cr, input int sr, input int scale);
      write_csr(REG_COS_YAW, cy[15:0]);
      write_csr(REG_SIN_YAW, sy[15:0]);
      write_csr(REG_COS_PITCH, cp[15:0]);
      write_csr(REG_SIN_PITCH, sp[15:0]);
      write_csr(REG_COS_ROLL, cr[15:0]);
      write_csr(REG_SIN_ROLL, sr[15:0]);
      write_csr(REG_VIEW_SCALE, scale[15:0]);
      csr_we <= 1'b0;
   endtask

   // Angles are mostly proper Q1.14 values, sometimes any 16-bit pattern.
   function automatic int random_trig();
      if ($urandom_range(0, 3) == 0) return $urandom_range(0, 65535);
      return int'($urandom_range(0, 32768)) - 16384;
   endfunction

   task automatic load_random_camera();
      load_camera(random_trig(), random_trig(), random_trig(), random_trig(),
                  random_trig(), random_trig(), $urandom_range(0, 1023));
   endtask

   // Most vertices sit in a modest box in front of the camera so the divide
   // path is exercised; the rest are full-range or hug the depth boundary.
   function automatic vertex_type random_vertex();
      vertex_type v;
      int pick;
      pick = $urandom_range(0, 99);
      v = vertex_type'(48'({$urandom(), $urandom()}));
      if (pick < 60) begin
         v.vertex_x = 16'(int'($urandom_range(0, 4096)) - 2048);
         v.vertex_y = 16'(int'($urandom_range(0, 4096)) - 2048);
         v.vertex_z = 16'(int'($urandom_range(0, 4096)) - 1536);
      end else if (pick < 75) begin
         v.vertex_z = 16'(int'($urandom_range(0, 16)) - 1288);
      end
      return v;
   endfunction

   task automatic send_random(input int count);
      repeat (count) send_vertex(random_vertex());
   endtask

   initial begin
      sb.load_defaults();
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed checks under the reset camera: origin, field extremes, the
      // depth boundary (exactly zero, just behind, just in front) and results
      // large enough to saturate.
      send_xyz(0, 0, 0);
      send_xyz(32767, 32767, 32767);
      send_xyz(-32768, -32768, -32768);
      send_xyz(32767, -32768, 0);
      send_xyz(-32768, 32767, 0);
      send_xyz(256, 256, -1280);
      send_xyz(256, 256, -1281);
      send_xyz(32767, 32767, -1279);
      send_xyz(-32768, -32768, -1279);
      send_xyz(1, -1, -1279);
      send_xyz(512, -512, 256);
      drain();

      // Write to the unused index; the camera must stay as it was.
      write_csr(REG_UNUSED, 16'h1234);
      // Extreme registers: full negative Q1.14 and the widest patterns, with
      // both limits of the view scale.
      load_camera(-16384, 16384, -16384, 16384, -16384, 16384, 1023);
      send_xyz(32767, -32768, 32767);
      send_xyz(-32768, 32767, -32768);
      send_xyz(1000, 2000, 3000);
      send_xyz(0, 0, 2560);
      drain();
      load_camera(32767, -32768, -32768, 32767, 32767, -32768, 0);
      send_xyz(32767, 32767, 32767);
      send_xyz(-32768, -32768, -32768);
      send_xyz(1, 2, 3);
      send_xyz(-300, 400, -100);
      drain();

      // Random camera settings with random vertex batches.
      repeat (4) begin
         load_random_camera();
         send_random(50);
         drain();
      end

      // Full-rate stretch, then a long receiver hold-off with the sender still
      // pushing so the pipeline fills and req_ready drops.
      load_camera(11585, 11585, 15137, -6270, 16384, 0, 300);
      calm = 1'b1;
      send_random(40);
      hold_request = 1'b1;
      send_random(80);
      calm = 1'b0;
      drain();

      // Mid-stream pause: the sender waits until everything is back before
      // continuing with the same camera.
      load_random_camera();
      send_random(40);
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      send_random(40);
      drain();

      $display("Run covered %0d vertex transactions across several camera settings,",
               sb.checked);
      $display("including %0d behind the camera and a long response stall.",
               sb.behind_seen);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
